// File: rtl/core/sao_pkg.sv
// sao_pkg: shared constants, types and helpers of the sprite alpha overlay.
// No dependencies; imported by sprite_alpha_overlay, sao_front and sao_blend.
`default_nettype none

package sao_pkg;

	// Sprite store geometry
	localparam int SPRITE_MAX_W = 64;
	localparam int SPRITE_MAX_H = 64;
	localparam int STORE_DEPTH  = SPRITE_MAX_W * SPRITE_MAX_H;
	localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int WORD_W       = 32;

	// Field widths
	localparam int COORD_W = 11;
	localparam int CHAN_W  = 8;
	localparam int POS_W   = 12;
	localparam int SIZE_W  = 7;
	localparam int OFS_W   = 13;	// coordinate minus signed position
	localparam int SUM_W   = 16;	// bg*(255-a) + fg*a tops out at 65025

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT   = 2'd0,
		REG_TOP    = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} sao_reg_t;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_BLEND = 1'b1
	} sao_mode_t;

	typedef struct packed {
		logic signed [POS_W-1:0] left;
		logic signed [POS_W-1:0] top;
		logic [SIZE_W-1:0]       width;
		logic [SIZE_W-1:0]       height;
	} sao_cfg_t;

	typedef struct packed {
		sao_mode_t          mode;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [CHAN_W-1:0]  c0;
		logic [CHAN_W-1:0]  c1;
		logic [CHAN_W-1:0]  c2;
		logic [CHAN_W-1:0]  alpha;
	} sao_in_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} sao_ram_req_t;

	// Blend item leaving the window stage; sprite word arrives alongside from the RAM
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [CHAN_W-1:0] bg0;
		logic [CHAN_W-1:0] bg1;
		logic [CHAN_W-1:0] bg2;
	} sao_s2_t;

	typedef struct packed {
		logic v1;
		logic v2;
		logic v3;
	} sao_stat_t;

	// floor(x/255) for x up to 255*255, exact over that range
	function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
		logic [SUM_W:0] t;
		t = {1'b0, x} + {9'd0, x[SUM_W-1:8]} + 17'd1;
		return t[SUM_W-1:8];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sprite_alpha_overlay.sv
// sprite_alpha_overlay: top level, configuration registers and the glue
// between sao_front, sao_ram and sao_blend. Depends on sao_pkg.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser: mode; tdata: col,row,c0,c1,c2,alpha
//  m_*      | out       | m_tvalid/m_tready  | tuser: in_window; tdata: c0,c1,c2
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index (register), cfg_data
//
// One item per clock, sustained while m_tready stays high. A blend item passes four
// register stages (input, window/RAM read, multiply, divide/output register) before
// its result is offered on m_*; a load item writes the sprite store from the input stage
// when that stage advances, and emits nothing.
// arst_n clears the valid bits and config registers (position 0,0, size 64x64);
// the sprite store is not cleared and must be loaded before blending over it.
// Each stage advances when it is empty or the stage behind it advances, so a held
// m_tready fills the bubbles first and then drops s_tready; nothing is lost or repeated.
// cfg_ready is always high; write configuration only while the pipeline is empty.
`default_nettype none

module sprite_alpha_overlay import sao_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// s_tuser: [0] mode
	// s_tdata: [10:0] pix_col, [21:11] pix_row, [29:22] chan0_in, [37:30] chan1_in,
	//          [45:38] chan2_in, [53:46] alpha_in, [55:54] zero
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	// m_tuser: [0] in_window
	// m_tdata: [7:0] chan0_out, [15:8] chan1_out, [23:16] chan2_out
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	sao_cfg_t          cfg_q;
	sao_in_t           in_item;
	sao_s2_t           s2;
	sao_ram_req_t      ram_req;
	sao_stat_t         stat;
	logic [WORD_W-1:0] sprite_word;
	logic              go3;
	logic              v1, v3;
	logic [CHAN_W-1:0] o0, o1, o2;

	// Configuration: always ready, decode by register index
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left   <= '0;
			cfg_q.top    <= '0;
			cfg_q.width  <= SIZE_W'(64);
			cfg_q.height <= SIZE_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (sao_reg_t'(cfg_index))
				REG_LEFT:   cfg_q.left   <= $signed(cfg_data[POS_W-1:0]);
				REG_TOP:    cfg_q.top    <= $signed(cfg_data[POS_W-1:0]);
				REG_WIDTH:  cfg_q.width  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[SIZE_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// Unpack the input transaction
	always_comb begin
		in_item.mode  = sao_mode_t'(s_tuser);
		in_item.col   = s_tdata[10:0];
		in_item.row   = s_tdata[21:11];
		in_item.c0    = s_tdata[29:22];
		in_item.c1    = s_tdata[37:30];
		in_item.c2    = s_tdata[45:38];
		in_item.alpha = s_tdata[53:46];
	end

	sao_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.go3      (go3),
		.s2       (s2),
		.ram_req  (ram_req),
		.v1_o     (v1)
	);

	sao_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (sprite_word)
	);

	sao_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.s2          (s2),
		.sprite_word (sprite_word),
		.go3         (go3),
		.v3_o        (v3),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_c0      (o0),
		.out_c1      (o1),
		.out_c2      (o2),
		.out_win     (m_tuser)
	);

	assign m_tdata = {o2, o1, o0};

	assign stat.v1 = v1;
	assign stat.v2 = s2.valid;
	assign stat.v3 = v3;

	// A full pipeline behind a stalled output must hold off the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.v1 && stat.v2 && stat.v3 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while every stage is full and stalled");

	// One item in the store stage at a time: never a read and a write together
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("sprite store read and written in the same cycle");

	// An accepted input transaction lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> stat.v1)
		else $error("accepted item missing from the first stage");

	// A stalled output keeps its window flag
	a_win_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
		else $error("in_window changed under a stalled output");

	// Store is read only for items going on to blend
	a_read_blend: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |=> stat.v2 && s2.hit)
		else $error("store read without an inside blend item behind it");

endmodule

`default_nettype wire

// File: rtl/core/sao_ram.sv
// sao_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sao_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sao_front.sv
// sao_front: input stage, window test, sprite store addressing and the
// stage that meets the RAM read data. Depends on sao_pkg.
`default_nettype none

module sao_front import sao_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire sao_in_t      in_item,
	input  wire sao_cfg_t     cfg,
	input  wire logic         go3,
	output sao_s2_t           s2,
	output sao_ram_req_t      ram_req,
	output logic              v1_o
);

	logic en1, en2;

	logic                     v1_s1;
	sao_in_t                  item_s1;
	logic signed [OFS_W-1:0]  fx_s1;
	logic signed [OFS_W-1:0]  fy_s1;

	logic signed [OFS_W-1:0]  fx_in, fy_in;
	logic [OFS_W-1:0]         w_lim, h_lim;
	logic                     hit;
	logic                     load_ok;

	sao_s2_t                  s2_s2;

	assign en2      = !s2_s2.valid || go3;
	assign en1      = !v1_s1 || en2;
	assign in_ready = en1;

	// Offset of the pixel from the sprite origin
	assign fx_in = $signed({2'b00, in_item.col}) - $signed({cfg.left[POS_W-1], cfg.left});
	assign fy_in = $signed({2'b00, in_item.row}) - $signed({cfg.top[POS_W-1], cfg.top});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1 <= in_item;
			fx_s1   <= fx_in;
			fy_s1   <= fy_in;
		end
	end

	// Clamp the window size to the store
	assign w_lim = (32'(cfg.width) > SPRITE_MAX_W) ? OFS_W'(SPRITE_MAX_W)
		: OFS_W'(cfg.width);
	assign h_lim = (32'(cfg.height) > SPRITE_MAX_H) ? OFS_W'(SPRITE_MAX_H)
		: OFS_W'(cfg.height);

	assign hit = !fx_s1[OFS_W-1] && !fy_s1[OFS_W-1]
		&& ($unsigned(fx_s1) < w_lim) && ($unsigned(fy_s1) < h_lim);

	assign load_ok = (32'(item_s1.col) < SPRITE_MAX_W) && (32'(item_s1.row) < SPRITE_MAX_H);

	// Touch the store only when the item advances, so a stall keeps the read data
	always_comb begin
		ram_req.we    = v1_s1 && (item_s1.mode == MODE_LOAD) && load_ok && en2;
		ram_req.waddr = ADDR_W'(32'(item_s1.row) * SPRITE_MAX_W + 32'(item_s1.col));
		ram_req.wdata = {item_s1.alpha, item_s1.c2, item_s1.c1, item_s1.c0};
		ram_req.re    = v1_s1 && (item_s1.mode == MODE_BLEND) && hit && en2;
		ram_req.raddr = ADDR_W'(32'($unsigned(fy_s1)) * SPRITE_MAX_W
			+ 32'($unsigned(fx_s1)));
	end

	// Load items end here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_s2 <= '0;
		end else if (en2) begin
			s2_s2.valid <= v1_s1 && (item_s1.mode == MODE_BLEND);
			s2_s2.hit   <= hit;
			s2_s2.bg0   <= item_s1.c0;
			s2_s2.bg1   <= item_s1.c1;
			s2_s2.bg2   <= item_s1.c2;
		end
	end

	assign s2   = s2_s2;
	assign v1_o = v1_s1;

endmodule

`default_nettype wire

// File: rtl/core/sao_blend.sv
// sao_blend: weighted sums of background and sprite, divide by 255 and
// the output register. Depends on sao_pkg.
`default_nettype none

module sao_blend import sao_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sao_s2_t           s2,
	input  wire logic [WORD_W-1:0] sprite_word,
	output logic                   go3,
	output logic                   v3_o,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [CHAN_W-1:0]      out_c0,
	output logic [CHAN_W-1:0]      out_c1,
	output logic [CHAN_W-1:0]      out_c2,
	output logic                   out_win
);

	logic en3, en4;

	logic [CHAN_W-1:0] a, na;
	logic [CHAN_W-1:0] fg0, fg1, fg2;

	logic              v3_s3;
	logic              inside_s3;
	logic [CHAN_W-1:0] bg0_s3, bg1_s3, bg2_s3;
	logic [SUM_W-1:0]  sum0_s3, sum1_s3, sum2_s3;

	logic              v4_s4;
	logic              win_s4;
	logic [CHAN_W-1:0] c0_s4, c1_s4, c2_s4;

	assign en4 = !v4_s4 || out_ready;
	assign en3 = !v3_s3 || en4;
	assign go3 = en3;

	assign a   = sprite_word[31:24];
	assign na  = CHAN_MAX - a;
	assign fg0 = sprite_word[7:0];
	assign fg1 = sprite_word[15:8];
	assign fg2 = sprite_word[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en3) begin
				v3_s3 <= s2.valid;
			end
			if (en4) begin
				v4_s4 <= v3_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			inside_s3 <= s2.hit;
			bg0_s3    <= s2.bg0;
			bg1_s3    <= s2.bg1;
			bg2_s3    <= s2.bg2;
			sum0_s3   <= SUM_W'(s2.bg0) * SUM_W'(na) + SUM_W'(fg0) * SUM_W'(a);
			sum1_s3   <= SUM_W'(s2.bg1) * SUM_W'(na) + SUM_W'(fg1) * SUM_W'(a);
			sum2_s3   <= SUM_W'(s2.bg2) * SUM_W'(na) + SUM_W'(fg2) * SUM_W'(a);
		end
		if (en4) begin
			win_s4 <= inside_s3;
			c0_s4  <= inside_s3 ? div255(sum0_s3) : bg0_s3;
			c1_s4  <= inside_s3 ? div255(sum1_s3) : bg1_s3;
			c2_s4  <= inside_s3 ? div255(sum2_s3) : bg2_s3;
		end
	end

	assign v3_o      = v3_s3;
	assign out_valid = v4_s4;
	assign out_c0    = c0_s4;
	assign out_c1    = c1_s4;
	assign out_c2    = c2_s4;
	assign out_win   = win_s4;

endmodule

`default_nettype wire

// File: bench/sprite_alpha_overlay_tb.sv
// sprite_alpha_overlay_tb: self-checking bench for the sprite alpha overlay.
// Drives sprite loads and background blends on the s_* stream, predicts each blended
// pixel from a shadow sprite store and window registers; depends on sao_pkg and the RTL.

module sprite_alpha_overlay_tb;
	import sao_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 8;
	localparam int DRAIN_CYCLES    = 8;	// four-stage blend path plus margin
	localparam int ITEMS_PER_PHASE = 210;
	localparam int PHASES          = 8;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int COORD_MAX       = (1 << COORD_W) - 1;

	// One blended pixel as it leaves on m_*
	typedef struct packed {
		logic [CHAN_W-1:0] c0;
		logic [CHAN_W-1:0] c1;
		logic [CHAN_W-1:0] c2;
		logic              in_window;
	} overlay_px_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;	// col, row, c0, c1, c2, alpha, zero pad (lowest first)
	logic                  s_tuser;	// mode
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;	// c0, c1, c2 (lowest first)
	logic                  m_tuser;	// in_window
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow of the window registers and the sprite store
	logic signed [POS_W-1:0] win_left   = '0;
	logic signed [POS_W-1:0] win_top    = '0;
	logic [SIZE_W-1:0]       win_width  = 7'd64;
	logic [SIZE_W-1:0]       win_height = 7'd64;
	logic [WORD_W-1:0]       texel_store [STORE_DEPTH];
	bit                      texel_written [STORE_DEPTH];

	overlay_px_t pending_overlays[$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          sink_hold      = 0;	// cycles the receiver still has to hold off
	bit          src_gaps_on    = 1'b1;
	bit          sink_stalls_on = 1'b1;

	sprite_alpha_overlay uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: any hang in a handshake ends the run here
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("sprite_alpha_overlay_tb: FAIL");
		$finish;
	end

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	// Store index under a background pixel, or -1 when it lies outside the window.
	// Sizes above the store saturate; a size of zero leaves the window empty.
	function automatic int window_index(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
		int fx, fy, w, h;
		w  = (win_width > SPRITE_MAX_W) ? SPRITE_MAX_W : int'(win_width);
		h  = (win_height > SPRITE_MAX_H) ? SPRITE_MAX_H : int'(win_height);
		fx = int'(col) - int'(win_left);
		fy = int'(row) - int'(win_top);
		if (fx < 0 || fy < 0 || fx >= w || fy >= h)
			return -1;
		return fy * SPRITE_MAX_W + fx;
	endfunction

	function automatic logic [CHAN_W-1:0] blend_channel(int bg, int fg, int a);
		return CHAN_W'((bg * (255 - a) + fg * a) / 255);
	endfunction

	// Expected output for one blend transaction; outside the window the pixel passes
	function automatic overlay_px_t expected_overlay(sao_in_t px);
		overlay_px_t res;
		logic [WORD_W-1:0] texel;
		int idx, a;
		idx           = window_index(px.col, px.row);
		res.c0        = px.c0;
		res.c1        = px.c1;
		res.c2        = px.c2;
		res.in_window = (idx >= 0);
		if (idx >= 0) begin
			texel  = texel_store[idx];
			a      = texel[31:24];
			res.c0 = blend_channel(px.c0, texel[7:0], a);
			res.c1 = blend_channel(px.c1, texel[15:8], a);
			res.c2 = blend_channel(px.c2, texel[23:16], a);
		end
		return res;
	endfunction

	// Offer one item, hold it until the transaction completes, then update the prediction
	task automatic send_item(sao_in_t px);
		int gap;
		int idx;
		gap = (src_gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= px.mode;
		s_tdata  <= {2'b00, px.alpha, px.c2, px.c1, px.c0, px.row, px.col};
		do @(posedge clk); while (!s_tready);
		if (px.mode == MODE_LOAD) begin
			// loads beyond the store are dropped by the block
			if (px.col < SPRITE_MAX_W && px.row < SPRITE_MAX_H) begin
				idx                = int'(px.row) * SPRITE_MAX_W + int'(px.col);
				texel_store[idx]   = {px.alpha, px.c2, px.c1, px.c0};
				texel_written[idx] = 1'b1;
			end
		end else begin
			pending_overlays = {pending_overlays, expected_overlay(px)};
		end
	endtask

	task automatic load_texel(int col, int row, int c0, int c1, int c2, int a);
		sao_in_t px;
		px.mode  = MODE_LOAD;
		px.col   = COORD_W'(col);
		px.row   = COORD_W'(row);
		px.c0    = CHAN_W'(c0);
		px.c1    = CHAN_W'(c1);
		px.c2    = CHAN_W'(c2);
		px.alpha = CHAN_W'(a);
		send_item(px);
	endtask

	// Blend one background pixel; load its sprite texel first if it was never written
	task automatic blend_at(int col, int row, int c0, int c1, int c2);
		sao_in_t px;
		int idx;
		idx = window_index(COORD_W'(col), COORD_W'(row));
		if (idx >= 0 && !texel_written[idx])
			load_texel(idx % SPRITE_MAX_W, idx / SPRITE_MAX_W, $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
		px.mode  = MODE_BLEND;
		px.col   = COORD_W'(col);
		px.row   = COORD_W'(row);
		px.c0    = CHAN_W'(c0);
		px.c1    = CHAN_W'(c1);
		px.c2    = CHAN_W'(c2);
		px.alpha = CHAN_W'($urandom_range(0, 255));	// ignored while blending
		send_item(px);
	endtask

	// Drop the input valid, wait out every expected result, then let loads settle
	task automatic wait_pipeline_empty();
		s_tvalid <= 1'b0;
		while (pending_overlays.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(sao_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LEFT:   win_left   = value;
			REG_TOP:    win_top    = value;
			REG_WIDTH:  win_width  = value[SIZE_W-1:0];
			REG_HEIGHT: win_height = value[SIZE_W-1:0];
		endcase
		@(posedge clk);
	endtask

	// Reprogram the whole window on an idle block; size writes carry junk above bit 6
	task automatic set_window(int left, int top, int w, int h);
		wait_pipeline_empty();
		write_reg(REG_LEFT, CFG_DATA_W'(left));
		write_reg(REG_TOP, CFG_DATA_W'(top));
		write_reg(REG_WIDTH, CFG_DATA_W'(($urandom_range(0, 31) << SIZE_W) | w));
		write_reg(REG_HEIGHT, CFG_DATA_W'(($urandom_range(0, 31) << SIZE_W) | h));
	endtask

	function automatic int random_position();
		return ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 2120)) - 72
			: int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic int random_size();
		return ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 127))
			: int'($urandom_range(1, 64));
	endfunction

	// Corners of the store, alpha extremes, and loads that must be dropped
	task automatic test_sprite_loads();
		load_texel(0, 0, 255, 0, 128, 255);
		load_texel(63, 63, 17, 200, 99, 0);
		load_texel(63, 0, 0, 255, 1, 128);
		load_texel(0, 63, 254, 3, 77, 1);
		load_texel(0, 1, 40, 80, 160, 200);
		load_texel(64, 0, 1, 2, 3, 4);
		load_texel(0, 64, 5, 6, 7, 8);
		load_texel(COORD_MAX, COORD_MAX, 9, 10, 11, 12);
	endtask

	// Reset window (0,0 size 64x64): opaque, transparent, partial, and just outside
	task automatic test_blend_edges();
		blend_at(0, 0, 0, 0, 0);
		blend_at(63, 63, 255, 255, 255);
		blend_at(63, 0, 100, 0, 255);
		blend_at(0, 63, 255, 255, 0);
		blend_at(0, 1, 7, 250, 128);
		blend_at(64, 0, 11, 22, 33);
		blend_at(0, 64, 44, 55, 66);
		blend_at(COORD_MAX, COORD_MAX, 255, 0, 255);
	endtask

	// Negative positions clip, zero size empties, oversize saturates, far corner works
	task automatic test_window_clipping();
		set_window(-63, -63, 64, 64);
		blend_at(0, 0, 90, 180, 45);
		blend_at(1, 0, 90, 180, 45);
		set_window(-63, -63, 0, 64);
		blend_at(0, 0, 12, 34, 56);
		set_window(2047, 2047, 127, 127);
		blend_at(COORD_MAX, COORD_MAX, 0, 128, 255);
		set_window(0, 0, 127, 100);
		blend_at(63, 63, 200, 100, 50);
		blend_at(64, 63, 200, 100, 50);
		blend_at(63, 64, 200, 100, 50);
		set_window(-2048, 0, 64, 64);
		blend_at(0, 0, 1, 2, 3);
	endtask

	// Hold the receiver off for a long stretch while the sender keeps streaming,
	// so the pipeline fills and s_tready has to drop
	task automatic test_backpressure();
		set_window(0, 0, 64, 64);
		src_gaps_on = 1'b0;
		sink_hold   = 400;
		repeat (32)
			blend_at($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255));
		while (sink_hold > 0) @(posedge clk);
		src_gaps_on = 1'b1;
	endtask

	// Phases of random traffic, each under its own window; the first ones hit the extremes
	task automatic test_random_phases();
		int useful, r, col, row, w_eff, h_eff;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_window(0, 0, 64, 64);
				1: set_window(2047, 2047, 64, 64);
				2: set_window(-2048, -2048, 64, 0);
				3: set_window(-40, -20, 127, 64);
				4: set_window(5, 1990, 1, 64);
				default: set_window(random_position(), random_position(), random_size(),
					random_size());
			endcase
			useful = 0;
			while (useful < ITEMS_PER_PHASE) begin
				// switch idling on and off in stretches
				if (useful % 50 == 0) begin
					src_gaps_on    = ($urandom_range(0, 3) != 0);
					sink_stalls_on = ($urandom_range(0, 3) != 0);
				end
				r = $urandom_range(0, 99);
				if (r < 20) begin
					if ($urandom_range(0, 6) == 0) begin
						col = $urandom_range(0, COORD_MAX);
						row = $urandom_range(0, COORD_MAX);
					end else begin
						col = $urandom_range(0, SPRITE_MAX_W - 1);
						row = $urandom_range(0, SPRITE_MAX_H - 1);
					end
					load_texel(col, row, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
					if (col < SPRITE_MAX_W && row < SPRITE_MAX_H)
						useful++;
				end else begin
					if (r < 80) begin
						// aim at the window and a small border around it
						w_eff = (win_width > SPRITE_MAX_W) ? SPRITE_MAX_W : int'(win_width);
						h_eff = (win_height > SPRITE_MAX_H) ? SPRITE_MAX_H : int'(win_height);
						col   = int'(win_left) + int'($urandom_range(0, w_eff + 7)) - 4;
						row   = int'(win_top) + int'($urandom_range(0, h_eff + 7)) - 4;
						col   = (col < 0) ? 0 : ((col > COORD_MAX) ? COORD_MAX : col);
						row   = (row < 0) ? 0 : ((row > COORD_MAX) ? COORD_MAX : row);
					end else begin
						col = $urandom_range(0, COORD_MAX);
						row = $urandom_range(0, COORD_MAX);
					end
					blend_at(col, row, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
					useful++;
				end
			end
		end
	endtask

	// Receiver: long hold-off on request, otherwise random stalls or always ready
	initial begin : sink_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
				m_tready   <= 1'b0;
				stall_left = idle_length() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Compare every output transaction against the oldest prediction
	always @(posedge clk) begin : check_results
		overlay_px_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_overlays.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: result with none expected, expected nothing, actual %h/%b",
					$time, m_tdata, m_tuser);
			end else begin
				want = pending_overlays.pop_front();
				check_field("chan0_out", want.c0, m_tdata[7:0]);
				check_field("chan1_out", want.c1, m_tdata[15:8]);
				check_field("chan2_out", want.c2, m_tdata[23:16]);
				check_field("in_window", want.in_window, m_tuser);
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= MODE_LOAD;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_LEFT;
		cfg_data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sprite_loads();
		test_blend_edges();
		test_window_clipping();
		test_backpressure();
		test_random_phases();

		wait_pipeline_empty();
		if (mismatch_count == 0 && pending_overlays.size() == 0)
			$display("sprite_alpha_overlay_tb: PASS");
		else
			$display("sprite_alpha_overlay_tb: FAIL");
		$finish;
	end

endmodule
